// File: hw/rtl/vst_pkg.sv
`timescale 1ns / 1ps

package vst_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int ANGLE_W   = 16;
    localparam int TRIG_W    = 16;
    localparam int FRAC_W    = TRIG_W - 1;
    localparam int ROT_IN_W  = 35;
    localparam int ROT_OUT_W = 36;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_ANGLE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH_ANGLE = 3'd4;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sin_yaw;
        logic signed [TRIG_W-1:0] cos_yaw;
        logic signed [TRIG_W-1:0] sin_pitch;
        logic signed [TRIG_W-1:0] cos_pitch;
    } trig_t;

endpackage

// File: hw/rtl/vst_trig_gen.sv
`timescale 1ns / 1ps

module vst_trig_gen (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          angle_write,
    input  logic [vst_pkg::ANGLE_W-1:0]   yaw_angle,
    input  logic [vst_pkg::ANGLE_W-1:0]   pitch_angle,
    output logic                          busy,
    output vst_pkg::trig_t                trig
);
    import vst_pkg::*;

    localparam logic [63:0] HALF_PI_Q62  = 64'h6487_ED51_10B4_611A;
    localparam logic [63:0] ROUND_HALF   = 64'h0000_4000_0000_0000;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
    localparam logic [14:0] QUARTER_N    = 15'd16384;
    localparam logic [3:0]  LAST_TERM    = 4'd13;
    localparam logic [TRIG_W-1:0] TRIG_MAX = 16'h7FFF;

    // low word of ceil(2^(64+l) / d), l = ceil(log2 d); the word above is always 1
    localparam logic [63:0] RECIP_6   = 64'(((128'd1 << 67) / 128'd6) + 128'd1);
    localparam logic [63:0] RECIP_20  = 64'(((128'd1 << 69) / 128'd20) + 128'd1);
    localparam logic [63:0] RECIP_42  = 64'(((128'd1 << 70) / 128'd42) + 128'd1);
    localparam logic [63:0] RECIP_72  = 64'(((128'd1 << 71) / 128'd72) + 128'd1);
    localparam logic [63:0] RECIP_110 = 64'(((128'd1 << 71) / 128'd110) + 128'd1);
    localparam logic [63:0] RECIP_156 = 64'(((128'd1 << 72) / 128'd156) + 128'd1);
    localparam logic [63:0] RECIP_210 = 64'(((128'd1 << 72) / 128'd210) + 128'd1);
    localparam logic [63:0] RECIP_272 = 64'(((128'd1 << 73) / 128'd272) + 128'd1);
    localparam logic [63:0] RECIP_342 = 64'(((128'd1 << 73) / 128'd342) + 128'd1);
    localparam logic [63:0] RECIP_420 = 64'(((128'd1 << 73) / 128'd420) + 128'd1);
    localparam logic [63:0] RECIP_506 = 64'(((128'd1 << 73) / 128'd506) + 128'd1);
    localparam logic [63:0] RECIP_600 = 64'(((128'd1 << 74) / 128'd600) + 128'd1);
    localparam logic [63:0] RECIP_702 = 64'(((128'd1 << 74) / 128'd702) + 128'd1);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_XMUL  = 6'b000010,
        ST_SQMUL = 6'b000100,
        ST_TMUL  = 6'b001000,
        ST_TDIV  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    function automatic logic [63:0] term_recip(input logic [3:0] k);
        logic [63:0] r;
        r = 64'd0;
        unique case (k)
            4'd1:    r = RECIP_6;
            4'd2:    r = RECIP_20;
            4'd3:    r = RECIP_42;
            4'd4:    r = RECIP_72;
            4'd5:    r = RECIP_110;
            4'd6:    r = RECIP_156;
            4'd7:    r = RECIP_210;
            4'd8:    r = RECIP_272;
            4'd9:    r = RECIP_342;
            4'd10:   r = RECIP_420;
            4'd11:   r = RECIP_506;
            4'd12:   r = RECIP_600;
            4'd13:   r = RECIP_702;
            default: r = 64'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] term_shift(input logic [3:0] k);
        logic [3:0] s;
        s = 4'd0;
        unique case (k)
            4'd1:    s = 4'd3;
            4'd2:    s = 4'd5;
            4'd3:    s = 4'd6;
            4'd4:    s = 4'd7;
            4'd5:    s = 4'd7;
            4'd6:    s = 4'd8;
            4'd7:    s = 4'd8;
            4'd8:    s = 4'd9;
            4'd9:    s = 4'd9;
            4'd10:   s = 4'd9;
            4'd11:   s = 4'd9;
            4'd12:   s = 4'd10;
            4'd13:   s = 4'd10;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    state_t        state_reg, state_next;
    logic          dirty_reg, dirty_next;
    logic [1:0]    slot_reg, slot_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [3:0]    k_reg, k_next;
    logic [1:0]    quad_reg, quad_next;
    trig_t         trig_reg, trig_next;

    logic [63:0]   mul_a_reg, mul_a_next;
    logic [63:0]   mul_b_reg, mul_b_next;
    logic [127:0]  acc_reg, acc_next;
    logic [63:0]   x2_reg, x2_next;
    logic [63:0]   term_reg, term_next;
    logic [63:0]   sum_reg, sum_next;

    logic [64:0]   mul_sum;
    logic [127:0]  acc_step;
    logic [64:0]   div_sum;
    logic [64:0]   div_shifted;
    logic [63:0]   div_quot;
    logic [63:0]   sum_round;
    logic [15:0]   mag;
    logic [TRIG_W-1:0] trig_val;
    logic          load_eval;
    logic [ANGLE_W-1:0] slot_angle;
    logic [14:0]   slot_n;

    // one bit of b per cycle, right-shifting accumulator
    assign mul_sum  = {1'b0, acc_reg[127:64]} + {1'b0, (mul_b_reg[0] ? mul_a_reg : 64'd0)};
    assign acc_step = {mul_sum, acc_reg[63:1]};

    // divide by reciprocal: (p * (2^64 + low word)) >> (64 + l)
    assign div_sum     = {1'b0, mul_a_reg} + {1'b0, acc_step[127:64]};
    assign div_shifted = div_sum >> term_shift(k_reg);
    assign div_quot    = div_shifted[63:0];

    assign sum_round = sum_reg + ROUND_HALF;
    assign mag       = sum_round[62:47];
    assign trig_val  = quad_reg[1] ? (16'd0 - mag) : (mag[15] ? TRIG_MAX : mag);

    always_comb
    begin
        state_next   = state_reg;
        dirty_next   = dirty_reg | angle_write;
        slot_next    = slot_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        quad_next    = quad_reg;
        trig_next    = trig_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        acc_next     = acc_reg;
        x2_next      = x2_reg;
        term_next    = term_reg;
        sum_next     = sum_reg;
        load_eval    = 1'b0;
        slot_angle   = '0;
        slot_n       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (dirty_reg)
                begin
                    dirty_next = angle_write;
                    slot_next  = 2'd0;
                    load_eval  = 1'b1;
                end
            end
            ST_XMUL:
            begin
                acc_next   = acc_step;
                mul_b_next = mul_b_reg >> 1;
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    mul_a_next = acc_step[77:14];
                    mul_b_next = acc_step[77:14];
                    term_next  = acc_step[77:14];
                    sum_next   = acc_step[77:14];
                    acc_next   = '0;
                    state_next = ST_SQMUL;
                end
            end
            ST_SQMUL:
            begin
                acc_next   = acc_step;
                mul_b_next = mul_b_reg >> 1;
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    x2_next    = acc_step[125:62];
                    mul_a_next = term_reg;
                    mul_b_next = acc_step[125:62];
                    acc_next   = '0;
                    k_next     = 4'd1;
                    state_next = ST_TMUL;
                end
            end
            ST_TMUL:
            begin
                acc_next   = acc_step;
                mul_b_next = mul_b_reg >> 1;
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    mul_a_next = acc_step[125:62];
                    mul_b_next = term_recip(k_reg);
                    acc_next   = '0;
                    state_next = ST_TDIV;
                end
            end
            ST_TDIV:
            begin
                acc_next   = acc_step;
                mul_b_next = mul_b_reg >> 1;
                cnt_next   = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    term_next = div_quot;
                    sum_next  = k_reg[0] ? (sum_reg - div_quot) : (sum_reg + div_quot);
                    if (k_reg == LAST_TERM)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        k_next     = k_reg + 4'd1;
                        mul_a_next = div_quot;
                        mul_b_next = x2_reg;
                        acc_next   = '0;
                        state_next = ST_TMUL;
                    end
                end
            end
            ST_DONE:
            begin
                unique case (slot_reg)
                    2'd0:    trig_next.sin_yaw   = trig_val;
                    2'd1:    trig_next.cos_yaw   = trig_val;
                    2'd2:    trig_next.sin_pitch = trig_val;
                    2'd3:    trig_next.cos_pitch = trig_val;
                    default: trig_next = trig_reg;
                endcase
                if (slot_reg == 2'd3)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    slot_next = slot_reg + 2'd1;
                    load_eval = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // cosine is the sine a quarter turn ahead
        if (load_eval)
        begin
            slot_angle = (slot_next[1] ? pitch_angle : yaw_angle)
                       + (slot_next[0] ? QUARTER_TURN : '0);
            slot_n     = slot_angle[14] ? (QUARTER_N - {1'b0, slot_angle[13:0]})
                                        : {1'b0, slot_angle[13:0]};
            quad_next  = slot_angle[15:14];
            mul_a_next = HALF_PI_Q62;
            mul_b_next = {49'd0, slot_n};
            acc_next   = '0;
            cnt_next   = '0;
            state_next = ST_XMUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            dirty_reg           <= 1'b0;
            slot_reg            <= '0;
            cnt_reg             <= '0;
            k_reg               <= '0;
            quad_reg            <= '0;
            trig_reg.sin_yaw    <= '0;
            trig_reg.cos_yaw    <= TRIG_MAX;
            trig_reg.sin_pitch  <= '0;
            trig_reg.cos_pitch  <= TRIG_MAX;
        end
        else
        begin
            state_reg <= state_next;
            dirty_reg <= dirty_next;
            slot_reg  <= slot_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            quad_reg  <= quad_next;
            trig_reg  <= trig_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        acc_reg     <= acc_next;
        x2_reg      <= x2_next;
        term_reg    <= term_next;
        sum_reg     <= sum_next;
    end

    assign busy = dirty_reg | (state_reg != ST_IDLE);
    assign trig = trig_reg;

endmodule

// File: hw/rtl/vst_rotate.sv
`timescale 1ns / 1ps

module vst_rotate (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic signed [vst_pkg::ROT_IN_W-1:0]   a,
    input  logic signed [vst_pkg::ROT_IN_W-1:0]   b,
    input  logic signed [vst_pkg::TRIG_W-1:0]     sin_val,
    input  logic signed [vst_pkg::TRIG_W-1:0]     cos_val,
    output logic                                  out_valid,
    output logic signed [vst_pkg::ROT_OUT_W-1:0]  a_rot,
    output logic signed [vst_pkg::ROT_OUT_W-1:0]  b_rot
);
    import vst_pkg::*;

    localparam int PROD_W = ROT_IN_W + TRIG_W;

    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] ac_reg, bs_reg, bc_reg, as_reg;
    logic                     rot_valid_reg;
    logic signed [ROT_OUT_W-1:0] a_rot_reg, b_rot_reg;
    logic signed [PROD_W:0]   a_sum, b_sum;

    // products
    always_ff @(posedge clk)
    begin
        ac_reg <= a * cos_val;
        bs_reg <= b * sin_val;
        bc_reg <= b * cos_val;
        as_reg <= a * sin_val;
    end

    // combine and drop the fraction, floor rounding
    assign a_sum = {ac_reg[PROD_W-1], ac_reg} - {bs_reg[PROD_W-1], bs_reg};
    assign b_sum = {bc_reg[PROD_W-1], bc_reg} + {as_reg[PROD_W-1], as_reg};

    always_ff @(posedge clk)
    begin
        a_rot_reg <= a_sum[ROT_OUT_W+FRAC_W-1:FRAC_W];
        b_rot_reg <= b_sum[ROT_OUT_W+FRAC_W-1:FRAC_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            rot_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= in_valid;
            rot_valid_reg  <= prod_valid_reg;
        end
    end

    assign out_valid = rot_valid_reg;
    assign a_rot     = a_rot_reg;
    assign b_rot     = b_rot_reg;

endmodule

// File: hw/rtl/view_space_vertex_transform.sv
`timescale 1ns / 1ps

// channel   | handshake          | payload
// ----------+--------------------+----------------------------------
// vertex in | start, busy        | vertex_x, vertex_y, vertex_z
// view out  | done               | view_x, view_y, view_z
// config    | cfg_we             | cfg_index, cfg_data
//
// one vertex per cycle while busy is low; done follows the offset,
// rotate and output registers; a yaw or pitch write holds busy high while the
// bit-serial multiply sine unit rebuilds the four sine and cosine values
// rst_n clears config to zero; sine 0 and cosine 32767 are ready at once
// done is a one-cycle strobe, the receiver cannot stall the pipeline

module view_space_vertex_transform (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [vst_pkg::COORD_W-1:0]   vertex_x,
    input  logic signed [vst_pkg::COORD_W-1:0]   vertex_y,
    input  logic signed [vst_pkg::COORD_W-1:0]   vertex_z,
    output logic                                 done,
    output logic signed [vst_pkg::COORD_W-1:0]   view_x,
    output logic signed [vst_pkg::COORD_W-1:0]   view_y,
    output logic signed [vst_pkg::COORD_W-1:0]   view_z,
    input  logic                                 cfg_we,
    input  logic [vst_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vst_pkg::COORD_W-1:0]          cfg_data
);
    import vst_pkg::*;

    function automatic logic [COORD_W-1:0] sat_coord(input logic [ROT_OUT_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v[ROT_OUT_W-1:COORD_W-1] == '0 || v[ROT_OUT_W-1:COORD_W-1] == '1)
            r = v[COORD_W-1:0];
        else if (v[ROT_OUT_W-1])
            r = {1'b1, {(COORD_W-1){1'b0}}};
        else
            r = {1'b0, {(COORD_W-1){1'b1}}};
        return r;
    endfunction

    logic [COORD_W-1:0]  camera_x_reg, camera_y_reg, camera_z_reg;
    logic [ANGLE_W-1:0]  yaw_angle_reg, pitch_angle_reg;
    logic                angle_write;
    logic                trig_busy;
    trig_t               trig;
    logic                accept;

    logic                diff_valid_reg;
    logic [DIFF_W-1:0]   dx_reg, dy_reg, dz_reg;
    logic [DIFF_W-1:0]   dy_d1_reg, dy_d2_reg;

    logic                yaw_valid;
    logic signed [ROT_OUT_W-1:0] x1, z1;
    logic [ROT_OUT_W-1:0] x1_d1_reg, x1_d2_reg;

    logic                pitch_valid;
    logic signed [ROT_OUT_W-1:0] y2, z2;

    logic                out_valid_reg;
    logic [COORD_W-1:0]  view_x_reg, view_y_reg, view_z_reg;

    assign angle_write = cfg_we && (cfg_index == REG_YAW_ANGLE || cfg_index == REG_PITCH_ANGLE);
    assign accept      = start && !trig_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            camera_x_reg    <= '0;
            camera_y_reg    <= '0;
            camera_z_reg    <= '0;
            yaw_angle_reg   <= '0;
            pitch_angle_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAMERA_X:    camera_x_reg    <= cfg_data;
                REG_CAMERA_Y:    camera_y_reg    <= cfg_data;
                REG_CAMERA_Z:    camera_z_reg    <= cfg_data;
                REG_YAW_ANGLE:   yaw_angle_reg   <= cfg_data[ANGLE_W-1:0];
                REG_PITCH_ANGLE: pitch_angle_reg <= cfg_data[ANGLE_W-1:0];
                default:         ;
            endcase
        end
    end

    vst_trig_gen u_trig_gen (
        .clk         (clk),
        .rst_n       (rst_n),
        .angle_write (angle_write),
        .yaw_angle   (yaw_angle_reg),
        .pitch_angle (pitch_angle_reg),
        .busy        (trig_busy),
        .trig        (trig)
    );

    // camera offset, and the delay registers for dy and x1
    always_ff @(posedge clk)
    begin
        dx_reg    <= {vertex_x[COORD_W-1], vertex_x} - {camera_x_reg[COORD_W-1], camera_x_reg};
        dy_reg    <= {vertex_y[COORD_W-1], vertex_y} - {camera_y_reg[COORD_W-1], camera_y_reg};
        dz_reg    <= {vertex_z[COORD_W-1], vertex_z} - {camera_z_reg[COORD_W-1], camera_z_reg};
        dy_d1_reg <= dy_reg;
        dy_d2_reg <= dy_d1_reg;
        x1_d1_reg <= x1;
        x1_d2_reg <= x1_d1_reg;
    end

    vst_rotate u_yaw_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (diff_valid_reg),
        .a         ({{(ROT_IN_W-DIFF_W){dx_reg[DIFF_W-1]}}, dx_reg}),
        .b         ({{(ROT_IN_W-DIFF_W){dz_reg[DIFF_W-1]}}, dz_reg}),
        .sin_val   (trig.sin_yaw),
        .cos_val   (trig.cos_yaw),
        .out_valid (yaw_valid),
        .a_rot     (x1),
        .b_rot     (z1)
    );

    vst_rotate u_pitch_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (yaw_valid),
        .a         ({{(ROT_IN_W-DIFF_W){dy_d2_reg[DIFF_W-1]}}, dy_d2_reg}),
        .b         (z1[ROT_IN_W-1:0]),
        .sin_val   (trig.sin_pitch),
        .cos_val   (trig.cos_pitch),
        .out_valid (pitch_valid),
        .a_rot     (y2),
        .b_rot     (z2)
    );

    always_ff @(posedge clk)
    begin
        view_x_reg <= sat_coord(x1_d2_reg);
        view_y_reg <= sat_coord(y2);
        view_z_reg <= sat_coord(z2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            diff_valid_reg <= accept;
            out_valid_reg  <= pitch_valid;
        end
    end

    assign busy   = trig_busy;
    assign done   = out_valid_reg;
    assign view_x = view_x_reg;
    assign view_y = view_y_reg;
    assign view_z = view_z_reg;

endmodule

// File: dv/tb_view_space_vertex_transform.sv
`timescale 1ns / 1ps

module tb_view_space_vertex_transform;
    import vst_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_PHASES = 12;
    localparam int VERTICES_PER_PHASE = 108;
    localparam int DRAIN_CYCLES = 12;
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [COORD_W-1:0] vertex_x = '0;
    logic signed [COORD_W-1:0] vertex_y = '0;
    logic signed [COORD_W-1:0] vertex_z = '0;
    logic done;
    logic signed [COORD_W-1:0] view_x;
    logic signed [COORD_W-1:0] view_y;
    logic signed [COORD_W-1:0] view_z;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0] cfg_data = '0;

    // shadow of the camera registers
    logic signed [COORD_W-1:0] eye_x = '0;
    logic signed [COORD_W-1:0] eye_y = '0;
    logic signed [COORD_W-1:0] eye_z = '0;
    logic [ANGLE_W-1:0] yaw = '0;
    logic [ANGLE_W-1:0] pitch = '0;
    trig_t trig;

    vec_t vertex_pending[$];
    vec_t view_expected[$];
    vec_t next_vertex;
    vec_t want_view;
    int sender_idle_pct = 0;
    int vertices_sent = 0;
    int results_checked = 0;
    int reg_writes = 0;
    int errors = 0;
    int cycles = 0;

    view_space_vertex_transform uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .vertex_x(vertex_x),
        .vertex_y(vertex_y),
        .vertex_z(vertex_z),
        .done(done),
        .view_x(view_x),
        .view_y(view_y),
        .view_z(view_z),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // round(sin(n * pi / 32768) * 32768) for n in 0..16384, taylor series in q2.62
    function automatic int quarter_wave(input int n);
        logic [63:0] arg;
        logic [63:0] arg_sq;
        logic [63:0] term;
        logic [63:0] acc;
        arg = (HALF_PI_Q62 >> 14) * 64'(n) + (((HALF_PI_Q62 & 64'h3FFF) * 64'(n)) >> 14);
        arg_sq = q62_mul(arg, arg);
        term = arg;
        acc = arg;
        for (int k = 1; k <= 13; k++)
        begin
            term = q62_mul(term, arg_sq) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return int'((acc + (64'd1 << 46)) >> 47);
    endfunction

    function automatic logic signed [TRIG_W-1:0] bam_sine(input logic [ANGLE_W-1:0] angle);
        int mag;
        if (angle[14])
            mag = quarter_wave(16384 - int'(angle[13:0]));
        else
            mag = quarter_wave(int'(angle[13:0]));
        if (angle[15])
            return TRIG_W'(-mag);
        return TRIG_W'((mag > 32767) ? 32767 : mag);
    endfunction

    function automatic trig_t trig_for(input logic [ANGLE_W-1:0] y_ang,
                                       input logic [ANGLE_W-1:0] p_ang);
        trig_t t;
        t.sin_yaw = bam_sine(y_ang);
        t.cos_yaw = bam_sine(ANGLE_W'(y_ang + QUARTER_TURN));
        t.sin_pitch = bam_sine(p_ang);
        t.cos_pitch = bam_sine(ANGLE_W'(p_ang + QUARTER_TURN));
        return t;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp32(input longint v);
        if (v > longint'(COORD_MAX))
            return COORD_MAX;
        if (v < longint'(COORD_MIN))
            return COORD_MIN;
        return COORD_W'(v);
    endfunction

    // camera offset, yaw about y, then pitch about x
    function automatic vec_t predict_view(input vec_t w);
        longint dx;
        longint dy;
        longint dz;
        longint sy;
        longint cy;
        longint sp;
        longint cp;
        longint yawed_x;
        longint yawed_z;
        longint pitched_y;
        longint pitched_z;
        vec_t v;
        dx = longint'(w.x) - longint'(eye_x);
        dy = longint'(w.y) - longint'(eye_y);
        dz = longint'(w.z) - longint'(eye_z);
        sy = longint'($signed(trig.sin_yaw));
        cy = longint'($signed(trig.cos_yaw));
        sp = longint'($signed(trig.sin_pitch));
        cp = longint'($signed(trig.cos_pitch));
        yawed_x = (dx * cy - dz * sy) >>> FRAC_W;
        yawed_z = (dz * cy + dx * sy) >>> FRAC_W;
        pitched_y = (dy * cp - yawed_z * sp) >>> FRAC_W;
        pitched_z = (yawed_z * cp + dy * sp) >>> FRAC_W;
        v.x = clamp32(yawed_x);
        v.y = clamp32(pitched_y);
        v.z = clamp32(pitched_z);
        return v;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        logic [COORD_W-1:0] bits;
        bits = $urandom();
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2, 3: return {{12{bits[19]}}, bits[19:0]};
            default: return bits;
        endcase
    endfunction

    // angle word, often on or next to a quarter turn, upper bits random
    function automatic logic [COORD_W-1:0] rand_angle_word();
        logic [COORD_W-1:0] bits;
        bits = $urandom();
        if ($urandom_range(0, 9) < 4)
            bits[ANGLE_W-1:0] = ANGLE_W'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
        return bits;
    endfunction

    function automatic void check_field(input string name, input logic signed [COORD_W-1:0] want,
                                        input logic signed [COORD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_CAMERA_X: eye_x = data;
            REG_CAMERA_Y: eye_y = data;
            REG_CAMERA_Z: eye_z = data;
            REG_YAW_ANGLE: yaw = data[ANGLE_W-1:0];
            REG_PITCH_ANGLE: pitch = data[ANGLE_W-1:0];
            default: ;
        endcase
        trig = trig_for(yaw, pitch);
        reg_writes++;
        // give a sine rebuild time to raise busy, then wait it out
        repeat (3) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_camera(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                                input logic [COORD_W-1:0] cz, input logic [COORD_W-1:0] ya,
                                input logic [COORD_W-1:0] pa);
        write_reg(REG_CAMERA_X, cx);
        write_reg(REG_CAMERA_Y, cy);
        write_reg(REG_CAMERA_Z, cz);
        write_reg(REG_YAW_ANGLE, ya);
        write_reg(REG_PITCH_ANGLE, pa);
    endtask

    task automatic wait_drained();
        while (vertex_pending.size() > 0 || view_expected.size() > 0 || start)
            @(posedge clk);
    endtask

    task automatic push_corners();
        vec_t corners[6];
        corners[0] = '{32'sd0, 32'sd0, 32'sd0};
        corners[1] = '{COORD_MAX, COORD_MAX, COORD_MAX};
        corners[2] = '{COORD_MIN, COORD_MIN, COORD_MIN};
        corners[3] = '{-32'sd1, 32'sd1, -32'sd1};
        corners[4] = '{COORD_MAX, COORD_MIN, 32'sd0};
        corners[5] = '{COORD_MIN, COORD_MAX, COORD_MAX};
        foreach (corners[i])
            vertex_pending.push_back(corners[i]);
        wait_drained();
    endtask

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // driver: one beat per accepted start
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                view_expected.push_back(predict_view('{vertex_x, vertex_y, vertex_z}));
                vertices_sent++;
            end
            if (!start || !busy)
            begin
                if (vertex_pending.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    next_vertex = vertex_pending.pop_front();
                    start <= 1'b1;
                    vertex_x <= next_vertex.x;
                    vertex_y <= next_vertex.y;
                    vertex_z <= next_vertex.z;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (view_expected.size() == 0)
            begin
                $display("%0t: unexpected beat: expected none, actual %0d %0d %0d",
                         $time, view_x, view_y, view_z);
                errors++;
            end
            else
            begin
                want_view = view_expected.pop_front();
                check_field("view_x", want_view.x, view_x);
                check_field("view_y", want_view.y, view_y);
                check_field("view_z", want_view.z, view_z);
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, view_expected.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        trig = trig_for(yaw, pitch);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // reset settings: zero camera, cosine clamped at zero angle
        push_corners();

        // unmapped indexes must be ignored
        for (int idx = REG_PITCH_ANGLE + 1; idx < 2 ** CFG_IDX_W; idx++)
            write_reg(CFG_IDX_W'(idx), $urandom());
        // extreme camera, full negative sine on pitch
        write_camera(COORD_MIN, COORD_MAX, COORD_MIN, 32'd8192, 32'd49152);
        push_corners();
        // opposite extremes, half turn of yaw, clamped sine on pitch
        write_camera(COORD_MAX, COORD_MIN, COORD_MAX, 32'd32768, 32'd16384);
        push_corners();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_camera(rand_coord(), rand_coord(), rand_coord(),
                         rand_angle_word(), rand_angle_word());
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_PITCH_ANGLE + 1, 2 ** CFG_IDX_W - 1)),
                          $urandom());
            if (phase < RANDOM_PHASES / 3)
                sender_idle_pct = 8;
            else if (phase < 2 * RANDOM_PHASES / 3)
                sender_idle_pct = 71;
            else
                sender_idle_pct = 0;
            for (int i = 0; i < VERTICES_PER_PHASE; i++)
                vertex_pending.push_back('{rand_coord(), rand_coord(), rand_coord()});
            wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("sent %0d vertices under %0d register writes, checked %0d view results",
                 vertices_sent, reg_writes, results_checked);
        $display("covered corner coordinates, saturation, quarter-turn angles, idle mixes");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/vst_pkg.sv
hw/rtl/vst_trig_gen.sv
hw/rtl/vst_rotate.sv
hw/rtl/view_space_vertex_transform.sv
dv/tb_view_space_vertex_transform.sv
